// ----- rtl/bounded_max_priority_queue_assert.svh -----
// Assertion helpers for the priority queue RTL.
`ifndef BOUNDED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define BOUNDED_MAX_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked at every edge out of reset.
`define BMPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BMPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bmpq_pkg.sv -----
package bmpq_pkg;

    localparam int unsigned CAPACITY = 8;

    typedef logic signed [31:0] value_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic   ins;
        logic   del;
        value_t value;
    } cell_cmd_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic   valid;
        logic   keep;
        value_t value;
    } cell_link_t;

endpackage

// ----- rtl/bmpq_cell.sv -----
// One slot of the sorted chain: holds, shifts back on insert, shifts forward on delete.
module bmpq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  bmpq_pkg::cell_cmd_t cmd,
    input  bmpq_pkg::cell_link_t left_link,
    input  bmpq_pkg::cell_link_t right_link,
    output bmpq_pkg::cell_link_t link,
    output logic                valid_next
);

    bmpq_pkg::value_t value_reg;
    bmpq_pkg::value_t value_next;
    logic             valid_reg;
    logic             keep;

    // Stays put on insert when it holds a value >= the new one (ties stay ahead).
    assign keep = valid_reg && (value_reg >= cmd.value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (cmd.ins)
        begin
            if (!keep)
            begin
                value_next = left_link.keep ? cmd.value : left_link.value;
            end
            valid_next = valid_reg | left_link.valid;
        end
        else if (cmd.del)
        begin
            value_next = right_link.value;
            valid_next = right_link.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.keep  = keep;
    assign link.value = value_reg;

endmodule

// ----- rtl/bounded_max_priority_queue.sv -----
// Bounded max priority queue of signed 32-bit values, largest first.
// Input channel s_*: one beat per operation. s_tuser is the operation
// (insert or delete largest), s_tdata the value to insert.
// Output channel m_*: exactly one result beat per input beat, in order.
// m_tdata carries the removed value (zero unless a delete succeeded),
// m_tuser the status (done / overflow / underflow) and the empty and full
// flags as they stand after the operation.
// Storage is a chain of CAPACITY cells; every cell compares against the
// incoming value in parallel and shifts to or from its neighbor, so an
// operation completes in the cycle it is accepted.
// The result beat is registered and appears in the cycle after its input beat
// is accepted. Throughput: 1 beat per cycle while m_tready is high, set by the
// compare-and-shift of the cell chain; the output register takes a new result
// in the same cycle the old one is taken.
// Stall: when m_tready is low and a result is held, s_tready drops and the
// queue holds its contents until the result is taken.
// Reset (rst_n low, async): the queue is empty and no result is pending.
`include "bounded_max_priority_queue_assert.svh"

module bounded_max_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] removed_value
    output logic [3:0]  m_tuser    // [1:0] status, [2] is_empty, [3] is_full
);

    localparam int unsigned CAP = bmpq_pkg::CAPACITY;

    localparam bmpq_pkg::cell_link_t HEAD_LINK = '{valid: 1'b1, keep: 1'b1, value: '0};
    localparam bmpq_pkg::cell_link_t TAIL_LINK = '{valid: 1'b0, keep: 1'b0, value: '0};

    bmpq_pkg::cell_link_t link     [CAP];
    logic [CAP-1:0]       valid_vec;
    logic [CAP-1:0]       valid_next_vec;
    bmpq_pkg::cell_cmd_t  cmd;

    logic                 accept;
    logic                 q_empty;
    logic                 q_full;
    bmpq_pkg::status_t    status;
    bmpq_pkg::value_t     removed;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [31:0]          m_data_reg;
    logic [3:0]           m_user_reg;

    // Room for a new result when the register is empty or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign q_empty = !valid_vec[0];
    assign q_full  = valid_vec[CAP-1];

    assign cmd.ins   = accept && (s_tuser == bmpq_pkg::OP_INSERT) && !q_full;
    assign cmd.del   = accept && (s_tuser == bmpq_pkg::OP_DELETE) && !q_empty;
    assign cmd.value = s_tdata;

    always_comb
    begin
        status  = bmpq_pkg::ST_DONE;
        removed = '0;
        if (s_tuser == bmpq_pkg::OP_INSERT)
        begin
            if (q_full)
            begin
                status = bmpq_pkg::ST_OVERFLOW;
            end
        end
        else if (q_empty)
        begin
            status = bmpq_pkg::ST_UNDERFLOW;
        end
        else
        begin
            removed = link[0].value;   // head is the largest entry
        end
    end

    // Cell chain; head cell sees a "keep" neighbor so it takes the value.
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        bmpq_pkg::cell_link_t left_l;
        bmpq_pkg::cell_link_t right_l;

        if (i == 0)
        begin : g_head
            assign left_l = HEAD_LINK;
        end
        else
        begin : g_mid_l
            assign left_l = link[i-1];
        end

        if (i == CAP - 1)
        begin : g_tail
            assign right_l = TAIL_LINK;
        end
        else
        begin : g_mid_r
            assign right_l = link[i+1];
        end

        bmpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_link  (left_l),
            .right_link (right_l),
            .link       (link[i]),
            .valid_next (valid_next_vec[i])
        );

        assign valid_vec[i] = link[i].valid;
    end

    assign m_valid_next = accept ? 1'b1 : (m_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= removed;
            m_user_reg <= {valid_next_vec[CAP-1], !valid_next_vec[0], status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Occupied cells always form a prefix of the chain.
    `BMPQ_ASSERT_IMPL(a_valid_prefix, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0, "valid cells not a prefix")
    // A successful insert adds exactly one entry.
    `BMPQ_ASSERT_NEXT(a_ins_grows, cmd.ins, $countones(valid_vec) == $countones($past(valid_vec)) + 1, "insert did not grow queue")
    // A successful delete drops exactly one entry.
    `BMPQ_ASSERT_NEXT(a_del_shrinks, cmd.del, $countones(valid_vec) + 1 == $countones($past(valid_vec)), "delete did not shrink queue")
    // Rejected operations leave the store untouched.
    `BMPQ_ASSERT_NEXT(a_reject_holds, accept && !cmd.ins && !cmd.del, valid_vec == $past(valid_vec), "rejected op changed queue")
    // An underflow result always reports an empty queue.
    `BMPQ_ASSERT_IMPL(a_underflow_empty, m_valid_reg && (m_user_reg[1:0] == bmpq_pkg::ST_UNDERFLOW), m_user_reg[2], "underflow without empty flag")

endmodule

// ----- verif/tb_bounded_max_priority_queue.sv -----
`timescale 1ns / 100ps

module tb_bounded_max_priority_queue;

    localparam int unsigned RANDOM_OPS  = 1300;
    localparam int unsigned LONG_HOLD   = 80;     // sink stall, in cycles
    localparam int unsigned DRAIN_WAIT  = 4;      // cycles after the last result
    localparam realtime     RUN_LIMIT   = 4ms;

    // One result beat as the block should emit it.
    typedef struct {
        bmpq_pkg::value_t  removed;
        bmpq_pkg::status_t status;
        logic              empty;
        logic              full;
    } queue_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic        s_tuser;   // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] removed_value
    logic [3:0]  m_tuser;   // [1:0] status, [2] is_empty, [3] is_full

    bounded_max_priority_queue DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Tracks the sorted contents and queues the result each accepted beat must produce.
    class sorted_queue_tracker;
        bmpq_pkg::value_t slots [bmpq_pkg::CAPACITY];
        int unsigned      depth;
        queue_result_t    pending_results [$];
        int unsigned      errors;
        int unsigned      results_seen;

        function new();
            depth        = 0;
            errors       = 0;
            results_seen = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Apply one accepted operation to the shadow store.
        function void note_operation(input logic op, input bmpq_pkg::value_t val);
            queue_result_t r;
            int unsigned   pos;
            int unsigned   i;
            r.removed = '0;
            r.status  = bmpq_pkg::ST_DONE;
            if (op == bmpq_pkg::OP_INSERT)
            begin
                if (depth >= bmpq_pkg::CAPACITY)
                begin
                    r.status = bmpq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    // new value lands behind every entry >= it (ties keep arrival order)
                    pos = 0;
                    while (pos < depth && slots[pos] >= val)
                        pos++;
                    for (i = depth; i > pos; i--)
                        slots[i] = slots[i - 1];
                    slots[pos] = val;
                    depth++;
                end
            end
            else
            begin
                if (depth == 0)
                begin
                    r.status = bmpq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    r.removed = slots[0];
                    for (i = 1; i < depth; i++)
                        slots[i - 1] = slots[i];
                    depth--;
                end
            end
            r.empty = (depth == 0);
            r.full  = (depth >= bmpq_pkg::CAPACITY);
            pending_results.push_back(r);
        endfunction

        task check_result(input logic [31:0] data, input logic [3:0] user);
            queue_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result beat %0d with nothing outstanding", results_seen));
                return;
            end
            want = pending_results.pop_front();
            if (data !== want.removed)
                report($sformatf("beat %0d removed_value %0d, want %0d",
                                 results_seen, $signed(data), want.removed));
            if (user[1:0] !== want.status)
                report($sformatf("beat %0d status %0d, want %0d",
                                 results_seen, user[1:0], want.status));
            if (user[2] !== want.empty)
                report($sformatf("beat %0d is_empty %b, want %b",
                                 results_seen, user[2], want.empty));
            if (user[3] !== want.full)
                report($sformatf("beat %0d is_full %b, want %b",
                                 results_seen, user[3], want.full));
        endtask
    endclass

    sorted_queue_tracker tracker = new();

    // Source idles only outside its steady stretches.
    logic src_steady;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one beat; returns at the edge it is taken. Valid stays high
    // straight into the next beat when no gap is drawn.
    task automatic push_operation(input logic op, input bmpq_pkg::value_t val);
        int unsigned gap;
        gap = src_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_operation(op, val);
    endtask

    // Hold off the source until every outstanding result has drained.
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // Mostly wide random words; some extremes and a narrow band to force ties.
    function automatic bmpq_pkg::value_t pick_value();
        case ($urandom_range(0, 9)) inside
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            [2:3]:   return bmpq_pkg::value_t'($urandom_range(0, 7)) - 32'sd4;
            default: return bmpq_pkg::value_t'($urandom());
        endcase
    endfunction

    // Sink: random backpressure, steady stretches, and two long stalls
    // that fill the output register and back up the input.
    initial
    begin
        int unsigned gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (tracker.results_seen == 300 || tracker.results_seen == 1000)
                gap = LONG_HOLD;
            else if ((tracker.results_seen / 89) % 4 == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 19);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            tracker.check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned insert_pct;
        logic        op;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= bmpq_pkg::OP_INSERT;
        src_steady <= 1'b0;
        rst_n      <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: underflow on empty, fill with extremes and ties, overflow,
        // drain completely, underflow again. Deletes carry junk values.
        push_operation(bmpq_pkg::OP_DELETE, 32'sh5A5A_A5A5);
        push_operation(bmpq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        push_operation(bmpq_pkg::OP_INSERT, 32'sh8000_0000);
        push_operation(bmpq_pkg::OP_INSERT, 32'sd0);
        push_operation(bmpq_pkg::OP_INSERT, -32'sd1);
        push_operation(bmpq_pkg::OP_INSERT, 32'sd0);
        push_operation(bmpq_pkg::OP_INSERT, 32'sd1);
        push_operation(bmpq_pkg::OP_INSERT, 32'sh8000_0000);
        push_operation(bmpq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        push_operation(bmpq_pkg::OP_INSERT, 32'sd5);
        push_operation(bmpq_pkg::OP_INSERT, 32'shFFFF_FFFF);
        repeat (bmpq_pkg::CAPACITY)
            push_operation(bmpq_pkg::OP_DELETE, bmpq_pkg::value_t'($urandom()));
        push_operation(bmpq_pkg::OP_DELETE, 32'shFFFF_FFFF);
        push_operation(bmpq_pkg::OP_INSERT, 32'sh0000_0000);
        push_operation(bmpq_pkg::OP_DELETE, 32'sh0000_0000);

        // Random: insert bias is redrawn every 50 beats so the queue swings
        // between empty and full.
        insert_pct = 50;
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            if (n == 650)
                drain_pause();
            src_steady <= ((n / 97) % 4 == 3);
            op = ($urandom_range(0, 99) < insert_pct) ? bmpq_pkg::OP_INSERT
                                                      : bmpq_pkg::OP_DELETE;
            push_operation(op, pick_value());
        end
        s_tvalid <= 1'b0;

        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("[%0t] timeout, %0d results outstanding",
                 $realtime, tracker.outstanding());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
